// ===== rtl/core/swmf_pkg.sv =====
package swmf_pkg;

    localparam int WINDOW      = 3;
    localparam int DETECTORS   = 2;
    localparam int AXES        = 2;
    localparam int SAMPLE_BITS = 10;

    localparam int CHANNELS    = DETECTORS * AXES;
    localparam int OUT_FIELDS  = 4;
    localparam int FIELD_W     = 10;
    localparam int MED_W       = 11;
    localparam int RANK_W      = $clog2(WINDOW + 1);
    localparam int MID         = WINDOW / 2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [MED_W-1:0]       t_med;

    typedef struct packed {
        logic [FIELD_W-1:0] det0_x;
        logic [FIELD_W-1:0] det0_y;
        logic [FIELD_W-1:0] det1_x;
        logic [FIELD_W-1:0] det1_y;
    } t_in_beat;

    typedef struct packed {
        t_med med0_x;
        t_med med0_y;
        t_med med1_x;
        t_med med1_y;
    } t_out_beat;

endpackage

// ===== rtl/core/sliding_window_median_filter.sv =====
// Running median over the last WINDOW frames of two position detectors, one
// window per coordinate channel, each result in half units (twice the middle
// sample for an odd window, the sum of the two middle samples for an even one).
// Every channel is a row of taps that shifts one sample per accepted beat, with
// the window cleared to zero at reset. A new frame is taken every cycle while
// o_in_stall is low: the median of the updated window is ranked in the same
// cycle and registered, in the skid entry if the output is held. A two-entry
// output buffer lets one more frame in while a result is held by a downstream
// stall; o_in_stall rises only when both entries are full.
module sliding_window_median_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  swmf_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output swmf_pkg::t_out_beat o_out_data
);

    logic                                w_accept;
    logic                                w_pop;
    swmf_pkg::t_sample                   w_in  [swmf_pkg::OUT_FIELDS];
    swmf_pkg::t_med                      w_med [swmf_pkg::OUT_FIELDS];
    swmf_pkg::t_out_beat                 w_beat;

    logic                                r_out_valid;
    logic                                n_out_valid;
    swmf_pkg::t_out_beat                 r_out;
    swmf_pkg::t_out_beat                 n_out;
    logic                                r_skid_valid;
    logic                                n_skid_valid;
    swmf_pkg::t_out_beat                 r_skid;
    swmf_pkg::t_out_beat                 n_skid;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_pop      = r_out_valid && !i_out_stall;

    assign w_in[0] = swmf_pkg::SAMPLE_BITS'(i_in_data.det0_x);
    assign w_in[1] = swmf_pkg::SAMPLE_BITS'(i_in_data.det0_y);
    assign w_in[2] = swmf_pkg::SAMPLE_BITS'(i_in_data.det1_x);
    assign w_in[3] = swmf_pkg::SAMPLE_BITS'(i_in_data.det1_y);

    genvar c;
    generate
        for (c = 0; c < swmf_pkg::OUT_FIELDS; c++) begin : g_ch
            if (c < swmf_pkg::CHANNELS) begin : g_live
                swmf_channel u_channel (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_shift  (w_accept),
                    .i_sample (w_in[c]),
                    .o_med    (w_med[c])
                );
            end else begin : g_unused
                assign w_med[c] = '0;
            end
        end
    endgenerate

    assign w_beat.med0_x = w_med[0];
    assign w_beat.med0_y = w_med[1];
    assign w_beat.med1_x = w_med[2];
    assign w_beat.med1_y = w_med[3];

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_pop || !r_out_valid) begin
            // refill the output register, skid entry first
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = w_beat;
                n_out_valid  = w_accept;
            end
        end else if (w_accept) begin
            // output held: park the new result
            n_skid       = w_beat;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat left no result");

    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("parked result lost during stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("output buffer not empty after reset");
`endif

endmodule

// ===== rtl/core/swmf_tap.sv =====
module swmf_tap (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  swmf_pkg::t_sample i_sample,
    output swmf_pkg::t_sample o_sample,
    output swmf_pkg::t_sample o_next
);

    swmf_pkg::t_sample r_sample;
    swmf_pkg::t_sample n_sample;

    // take the incoming sample (new input or the previous tap's) on each accepted beat
    always_comb begin
        n_sample = i_shift ? i_sample : r_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_next   = n_sample;

endmodule

// ===== rtl/core/swmf_channel.sv =====
module swmf_channel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  swmf_pkg::t_sample i_sample,
    output swmf_pkg::t_med    o_med
);

    localparam int SUM_W = swmf_pkg::SAMPLE_BITS + 1;

    swmf_pkg::t_sample                    w_cur  [swmf_pkg::WINDOW];
    swmf_pkg::t_sample                    w_next [swmf_pkg::WINDOW];
    logic [swmf_pkg::RANK_W-1:0]          w_rank [swmf_pkg::WINDOW];
    swmf_pkg::t_sample                    w_hi;
    swmf_pkg::t_sample                    w_lo;
    logic [SUM_W-1:0]                     w_sum;

    genvar k;
    generate
        for (k = 0; k < swmf_pkg::WINDOW; k++) begin : g_tap
            swmf_pkg::t_sample w_feed;
            if (k == 0) begin : g_head
                assign w_feed = i_sample;
            end else begin : g_body
                assign w_feed = w_cur[k-1];
            end
            swmf_tap u_tap (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (i_shift),
                .i_sample (w_feed),
                .o_sample (w_cur[k]),
                .o_next   (w_next[k])
            );
        end
    endgenerate

    // rank every tap of the window after this beat; on a tie the lower tap takes the lower rank
    always_comb begin
        for (int i = 0; i < swmf_pkg::WINDOW; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < swmf_pkg::WINDOW; j++) begin
                if (j != i) begin
                    if ((w_next[j] < w_next[i]) ||
                        ((w_next[j] == w_next[i]) && (j < i))) begin
                        w_rank[i] = w_rank[i] + swmf_pkg::RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        w_hi = '0;
        for (int i = 0; i < swmf_pkg::WINDOW; i++) begin
            if (w_rank[i] == swmf_pkg::RANK_W'(swmf_pkg::MID)) begin
                w_hi = w_hi | w_next[i];
            end
        end
    end

    generate
        if ((swmf_pkg::WINDOW % 2) == 0) begin : g_even
            always_comb begin
                w_lo = '0;
                for (int i = 0; i < swmf_pkg::WINDOW; i++) begin
                    if (w_rank[i] == swmf_pkg::RANK_W'(swmf_pkg::MID - 1)) begin
                        w_lo = w_lo | w_next[i];
                    end
                end
            end
        end else begin : g_odd
            assign w_lo = w_hi;
        end
    endgenerate

    assign w_sum = SUM_W'(w_hi) + SUM_W'(w_lo);
    assign o_med = swmf_pkg::MED_W'(w_sum);

endmodule
